// ----- sv/modular_exponentiation_top_defines.svh -----
// Assertion macros shared by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ME_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modexp check failed");

// Next-cycle implication, disabled during reset.
`define ME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modexp check failed");

`endif

// ----- sv/modexp_pkg.sv -----
// Shared types for the modular exponentiation block.
package modexp_pkg;

  // Which operation the shared modular multiplier is running.
  typedef enum logic [1:0] {
    JOB_REDUCE,
    JOB_ACC,
    JOB_SQR
  } job_t;

endpackage

// ----- sv/modular_exponentiation_top.sv -----
// Modular exponentiation: one item in, base^exponent mod modulus out, using
// right-to-left square-and-multiply. All modular products run on a single
// shift-and-add multiplier that walks the multiplier MSB first: each bit
// step doubles the partial sum, then adds the multiplicand when the bit is
// set, and each of these ends in one conditional subtract of the modulus. An
// item costs one product to reduce the base, then, for each exponent bit up
// to the highest set bit, one squaring plus one more product when the bit is
// set, with a pass through the sequencing state S_STEP per bit. A zero
// modulus skips the products and gives 0. in_ready is high only while no
// item is in progress. The result sits in an output register, so the next
// item may be taken while it waits for out_ready.
module modular_exponentiation_top #(
  parameter int WORD_BITS = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] base_value,
  input  logic [WORD_BITS-1:0] exponent_value,
  input  logic [WORD_BITS-1:0] modulus_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] power_result
);
  import modexp_pkg::*;

  localparam int CW = $clog2(WORD_BITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_STEP,
    S_DONE
  } state_t;

  state_t               state;
  job_t                 job;
  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] expo;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] sq;
  logic [WORD_BITS-1:0] mul_a;
  logic [WORD_BITS-1:0] mul_b;
  logic [WORD_BITS-1:0] prod;
  logic [CW-1:0]        cnt;
  logic                 phase;

  // Shared add / compare / subtract unit.
  logic [WORD_BITS-1:0] addend;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] red;

  always_comb begin
    if (phase) begin
      addend = mul_b[WORD_BITS-1] ? mul_a : '0;
    end else begin
      addend = prod;
    end
    sum  = {1'b0, prod} + {1'b0, addend};
    diff = sum - {1'b0, modulus};
    red  = (sum >= {1'b0, modulus}) ? diff[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            modulus <= modulus_value;
            expo    <= exponent_value;
            acc     <= (modulus_value <= WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            mul_a   <= WORD_BITS'(1);
            mul_b   <= base_value;
            prod    <= '0;
            cnt     <= CW'(WORD_BITS);
            phase   <= 1'b0;
            job     <= JOB_REDUCE;
            if (modulus_value == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (!phase) begin
            prod  <= red;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (cnt != CW'(1)) begin
              prod  <= red;
              mul_b <= {mul_b[WORD_BITS-2:0], 1'b0};
              cnt   <= cnt - CW'(1);
            end else begin
              unique case (job)
                JOB_REDUCE: begin
                  sq    <= red;
                  state <= S_STEP;
                end
                JOB_ACC: begin
                  acc   <= red;
                  mul_a <= sq;
                  mul_b <= sq;
                  prod  <= '0;
                  cnt   <= CW'(WORD_BITS);
                  job   <= JOB_SQR;
                end
                JOB_SQR: begin
                  sq    <= red;
                  expo  <= expo >> 1;
                  state <= S_STEP;
                end
                default: begin
                  state <= S_STEP;
                end
              endcase
            end
          end
        end
        S_STEP: begin
          prod  <= '0;
          cnt   <= CW'(WORD_BITS);
          phase <= 1'b0;
          if (expo == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_MUL;
            if (expo[0]) begin
              mul_a <= acc;
              mul_b <= sq;
              job   <= JOB_ACC;
            end else begin
              mul_a <= sq;
              mul_b <= sq;
              job   <= JOB_SQR;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            power_result <= acc;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/modexp_checker.sv -----
// Port-level checks for the modular exponentiation block, bound to its top.
`include "modular_exponentiation_top_defines.svh"

module modexp_checker #(
  parameter int WORD_BITS = 31
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] power_result
);

  // A stalled result holds.
  `ME_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(power_result))

  // An accepted item keeps the block busy.
  `ME_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A new result only appears after the block was busy.
  `ME_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(!in_ready))

endmodule

bind modular_exponentiation_top modexp_checker #(.WORD_BITS(WORD_BITS)) u_modexp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .power_result (power_result)
);

// ----- sim/tb_modular_exponentiation_top.sv -----
// Testbench for modular_exponentiation_top: predicted base^exp mod m vs. block results.
`timescale 1ns / 1ps

module tb_modular_exponentiation_top;

  localparam int W = 31;
  localparam int HOLD_CYCLES = 10000;
  localparam int TAIL_CYCLES = 4000;

  typedef struct packed {
    logic [W-1:0] base;
    logic [W-1:0] expo;
    logic [W-1:0] modulus;
  } pow_op_t;

  typedef struct packed {
    pow_op_t      op;
    logic [W-1:0] power;
  } pow_expect_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [W-1:0] base_value = '0;
  logic [W-1:0] exponent_value = '0;
  logic [W-1:0] modulus_value = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-1:0] power_result;

  pow_op_t     pending_ops[$];
  pow_expect_t expected_powers[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;

  modular_exponentiation_top #(.WORD_BITS(W)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .base_value    (base_value),
    .exponent_value(exponent_value),
    .modulus_value (modulus_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .power_result  (power_result)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [W-1:0] predict_power(input pow_op_t op);
    longint unsigned m;
    longint unsigned acc;
    longint unsigned sq;
    if (op.modulus == '0) return '0;
    m   = 64'(op.modulus);
    acc = 64'd1 % m;
    sq  = 64'(op.base) % m;
    for (int i = 0; i < W; i++) begin
      if (op.expo[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[W-1:0];
  endfunction

  function automatic pow_op_t make_op(input logic [W-1:0] b, input logic [W-1:0] e,
                                      input logic [W-1:0] m);
    pow_op_t op;
    op.base    = b;
    op.expo    = e;
    op.modulus = m;
    return op;
  endfunction

  // mostly short exponents to keep the run short; one in eight spans all bits
  function automatic pow_op_t random_op();
    pow_op_t     op;
    int unsigned w;
    logic [31:0] r;
    case ($urandom_range(7))
      0:       op.base = W'($urandom_range(0, 15));
      1:       op.base = '1;
      default: op.base = W'($urandom);
    endcase
    if ($urandom_range(7) == 0) begin
      op.expo = W'($urandom);
    end else begin
      w = $urandom_range(0, 10);
      r = $urandom & ((32'd1 << w) - 32'd1);
      op.expo = W'(r);
    end
    case ($urandom_range(7))
      0, 1:    op.modulus = W'($urandom_range(1, 255));
      2:       op.modulus = '1;
      3:       op.modulus = W'(32'd1 << $urandom_range(0, W - 1));
      4:       op.modulus = W'($urandom_range(1, 3));
      default: begin
        op.modulus = W'($urandom);
        if (op.modulus == '0) op.modulus = W'(1);
      end
    endcase
    return op;
  endfunction

  task automatic add_op(input pow_op_t op);
    pending_ops = {pending_ops, op};
  endtask

  // driver
  always @(posedge clk) begin
    pow_op_t     op;
    pow_expect_t exp_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        exp_item.op    = make_op(base_value, exponent_value, modulus_value);
        exp_item.power = predict_power(exp_item.op);
        expected_powers = {expected_powers, exp_item};
      end
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        op = pending_ops.pop_front();
        in_valid       <= 1'b1;
        base_value     <= op.base;
        exponent_value <= op.expo;
        modulus_value  <= op.modulus;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    pow_expect_t exp_item;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_powers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: power_result=%0d", power_result);
        end else begin
          exp_item = expected_powers.pop_front();
          if (power_result !== exp_item.power) begin
            mismatches++;
            if (mismatches <= 10)
              $display("power_result mismatch: base=%0d exp=%0d mod=%0d expected %0d got %0d",
                       exp_item.op.base, exp_item.op.expo, exp_item.op.modulus,
                       exp_item.power, power_result);
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_random(input int n);
    repeat (n) add_op(random_op());
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || expected_powers.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    logic [W-1:0] all1;
    all1 = '1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, zero exponent, modulus one, reduced base
    add_op(make_op(0, 0, 1));
    add_op(make_op(5, 0, 7));
    add_op(make_op(all1, 0, all1));
    add_op(make_op(all1, all1, 1));
    add_op(make_op(12345, 678, 1));
    add_op(make_op(all1, all1, all1));
    add_op(make_op(all1, 1, all1));
    add_op(make_op(all1, 2, all1 - W'(1)));
    add_op(make_op(0, 5, 13));
    add_op(make_op(0, all1, all1));
    add_op(make_op(2, 30, all1));
    add_op(make_op(all1, all1, 2));
    add_op(make_op(1, all1, all1 - W'(1)));
    add_op(make_op(100, 1, 1000));
    add_op(make_op(all1, 2, W'(32'd1 << 30)));
    add_op(make_op(3, W'(32'd1 << 30), 1000003));
    add_op(make_op(97, 97, 97));
    add_op(make_op(all1 - W'(1), W'(32'h2AAA_AAAA), all1));
    add_op(make_op(W'(32'h5555_5555), W'(32'h5555_5555), W'(32'h2AAA_AAAB)));
    add_op(make_op(7, 3, all1));
    wait_drained();

    queue_random(50);
    wait_drained();

    send_idle_pct <= 50;
    queue_random(60);
    wait_drained();

    send_idle_pct  <= 0;
    recv_stall_pct <= 50;
    queue_random(60);
    wait_drained();

    send_idle_pct  <= 7;
    recv_stall_pct <= 7;
    queue_random(60);
    wait_drained();

    // receiver holds off long enough for the block to back up
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_req       <= 1'b1;
    queue_random(40);
    @(negedge clk);
    hold_req <= 1'b0;
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_powers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/modexp_pkg.sv
sv/modular_exponentiation_top.sv
sv/modexp_checker.sv
sim/tb_modular_exponentiation_top.sv
